// ----- rtl/quadratic_cost_accumulator_macros.svh -----
// assertion helpers for the accumulator rtl
`ifndef QUADRATIC_COST_ACCUMULATOR_MACROS_SVH
`define QUADRATIC_COST_ACCUMULATOR_MACROS_SVH

// checked only outside reset
`define QCA_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define QCA_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/qca_pkg.sv -----
package qca_pkg;

  localparam int FRAC_BITS = 32;
  localparam int DW        = 64;
  localparam int WW        = 2 * DW;

  localparam logic [2:0] OP_LOAD_OBS   = 3'd0;
  localparam logic [2:0] OP_ADD_OBS    = 3'd1;
  localparam logic [2:0] OP_ADD_CONST  = 3'd2;
  localparam logic [2:0] OP_ADD_QUAD   = 3'd3;
  localparam logic [2:0] OP_QUERY      = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;

  typedef enum logic [1:0] {
    MODE_MUL  = 2'd0,
    MODE_DIV  = 2'd1,
    MODE_SQRT = 2'd2
  } qca_mode_t;

  typedef struct packed {
    logic            start;
    qca_mode_t       mode;
    logic [WW-1:0]   num;
    logic [DW-1:0]   den;
  } qca_req_t;

  // clamp a wide two's complement value to the signed 64-bit range
  function automatic logic [DW-1:0] sat64(input logic [WW-1:0] x);
    logic all_same;
    all_same = (x[WW-1:DW-1] == {(DW+1){1'b0}}) || (x[WW-1:DW-1] == {(DW+1){1'b1}});
    if (all_same) return x[DW-1:0];
    else if (x[WW-1]) return {1'b1, {(DW-1){1'b0}}};
    else return {1'b0, {(DW-1){1'b1}}};
  endfunction

endpackage

// ----- rtl/qca_serial.sv -----
module qca_serial import qca_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  qca_req_t        req,
  output logic [WW-1:0]   res,
  output logic            done
);

  logic            busy;
  logic [6:0]      cnt;
  logic [6:0]      last;
  qca_mode_t       mode;
  logic [DW-1:0]   den;
  logic [WW-1:0]   acc;
  logic [WW-1:0]   acc_next;
  logic [DW+1:0]   rem;
  logic [DW+1:0]   rem_next;
  logic [DW-1:0]   root;
  logic [DW-1:0]   root_next;

  logic [DW:0]     mul_sum;
  logic [DW:0]     div_r2;
  logic [DW:0]     div_diff;
  logic            div_ge;
  logic [DW+3:0]   sq_r2;
  logic [DW+3:0]   sq_trial;
  logic [DW+3:0]   sq_diff;
  logic            sq_ge;

  // one bit of the result per cycle
  always_comb begin
    mul_sum  = {1'b0, acc[WW-1:DW]} + {1'b0, (acc[0] ? den : {DW{1'b0}})};
    div_r2   = {rem[DW-1:0], acc[WW-1]};
    div_diff = div_r2 - {1'b0, den};
    div_ge   = div_r2 >= {1'b0, den};
    sq_r2    = {rem, acc[WW-1:WW-2]};
    sq_trial = {2'b00, root, 2'b01};
    sq_diff  = sq_r2 - sq_trial;
    sq_ge    = sq_r2 >= sq_trial;
    acc_next  = acc;
    rem_next  = rem;
    root_next = root;
    last      = 7'd63;
    unique case (mode)
      MODE_MUL: begin
        acc_next = {mul_sum, acc[DW-1:1]};
      end
      MODE_DIV: begin
        acc_next = {acc[WW-2:0], div_ge};
        rem_next = {2'b00, (div_ge ? div_diff[DW-1:0] : div_r2[DW-1:0])};
        last     = 7'd127;
      end
      MODE_SQRT: begin
        acc_next  = {acc[WW-3:0], 2'b00};
        rem_next  = sq_ge ? sq_diff[DW+1:0] : sq_r2[DW+1:0];
        root_next = {root[DW-2:0], sq_ge};
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.mode;
      den  <= req.den;
      acc  <= req.num;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      acc  <= acc_next;
      rem  <= rem_next;
      root <= root_next;
    end
  end

  assign res = (mode == MODE_SQRT) ? {{DW{1'b0}}, root} : acc;

endmodule

// ----- rtl/quadratic_cost_accumulator.sv -----
// Quadratic cost accumulator: holds a*t^2+b*t+c in signed Q32.32 registers and answers
// every input word with one result word (minimum, argmin, and for a query the interval
// where the cost lies below the level). All products, quotients and the square root run
// bit serially through one shared shift unit: a multiply takes 64 steps, a divide 128,
// a square root 64, each preceded by a load and followed by a hand back of the result.
// A zero squared coefficient ends the work at the degenerate check. One item is
// worked on at a time; the next word is taken while a finished result still waits
// in the output register.
`include "quadratic_cost_accumulator_macros.svh"
module quadratic_cost_accumulator import qca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           operation,
  input  logic signed [DW-1:0] value,
  input  logic signed [DW-1:0] coef_a,
  input  logic signed [DW-1:0] coef_b,
  input  logic signed [DW-1:0] coef_c,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] min_value,
  output logic signed [DW-1:0] min_position,
  output logic signed [DW-1:0] interval_low,
  output logic signed [DW-1:0] interval_high,
  output logic                 interval_found,
  output logic                 degenerate
);

  // sequencer, one-hot
  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_SQY  = 10'b0000000010,  // y squared
    ST_UPD  = 10'b0000000100,  // coefficient update
    ST_CHK  = 10'b0000001000,  // degenerate check, start b squared
    ST_BSQ  = 10'b0000010000,  // b squared
    ST_DVT  = 10'b0000100000,  // b^2 / |a|
    ST_DVP  = 10'b0001000000,  // |b| / |a|
    ST_QMS  = 10'b0010000000,  // |a| * |c - level|
    ST_SQS  = 10'b0100000000,  // square root of quarter discriminant
    ST_DVR  = 10'b1000000000   // half width divide, then result
  } state_t;

  localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

  state_t          state;
  qca_req_t        req;
  logic [WW-1:0]   res;
  logic            done;

  // coefficient state
  logic [DW-1:0]   sq;
  logic [DW-1:0]   lin;
  logic [DW-1:0]   cst;

  // latched input word
  logic [2:0]      opr;
  logic [DW-1:0]   vin;
  logic [DW-1:0]   ca;
  logic [DW-1:0]   cb;
  logic [DW-1:0]   cc;

  // intermediate results
  logic [WW-1:0]   bsq;
  logic [WW-1:0]   tq;
  logic [WW-1:0]   pq;
  logic [WW-1:0]   rq;
  logic            found;
  logic            degen;
  logic            fin;

  // derived values
  logic [DW-1:0]   ma;
  logic [DW-1:0]   mb;
  logic [DW-1:0]   mv_in;
  logic [DW+1:0]   m2y;
  logic [WW-1:0]   ysq;
  logic [DW:0]     cl;
  logic [DW-1:0]   cm;
  logic            an;
  logic            bn;
  logic            cn;
  logic [WW-1:0]   quarter;
  logic            qpos;
  logic            q_found;
  logic [WW-1:0]   q_dq;
  logic [WW-1:0]   am;
  logic [DW-1:0]   sq_next;
  logic [DW-1:0]   lin_next;
  logic [DW-1:0]   cst_next;
  logic            start_next;

  qca_serial u_serial (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .res  (res),
    .done (done)
  );

  // a finished result waiting for the output register also holds off the input
  assign in_stall = (state != ST_IDLE) || fin;
  assign an       = sq[DW-1];
  assign bn       = lin[DW-1];
  assign ma       = an ? (~sq + DW'(1)) : sq;
  assign mb       = bn ? (~lin + DW'(1)) : lin;
  assign mv_in    = value[DW-1] ? (~value + DW'(1)) : value;
  // -2y, wide enough for the most negative y
  assign m2y      = ~{vin[DW-1], vin, 1'b0} + (DW+2)'(1);
  assign ysq      = res >> FRAC_BITS;
  assign cl       = {cst[DW-1], cst} - {vin[DW-1], vin};
  assign cn       = cl[DW];
  assign cm       = cn ? (~cl[DW-1:0] + DW'(1)) : cl[DW-1:0];
  assign quarter  = bsq >> 2;

  // interval test from quarter discriminant, res holds |a|*|c - level| here
  always_comb begin
    qpos    = (an == cn) && (res != '0);
    q_found = 1'b0;
    q_dq    = '0;
    if (!qpos) begin
      q_found = (bsq != '0) || (res != '0);
      q_dq    = quarter + res;
    end else if (quarter >= res) begin
      q_found = (quarter != res) || (bsq[1:0] != 2'b00);
      q_dq    = quarter - res;
    end
  end

  // coefficient update, saturating
  always_comb begin
    sq_next  = sq;
    lin_next = lin;
    cst_next = cst;
    case (opr)
      OP_LOAD_OBS: begin
        sq_next  = ONE;
        lin_next = sat64(WW'(signed'(m2y)));
        cst_next = sat64(ysq);
      end
      OP_ADD_OBS: begin
        sq_next  = sat64(WW'(signed'(sq)) + WW'(ONE));
        lin_next = sat64(WW'(signed'(lin)) + WW'(signed'(m2y)));
        cst_next = sat64(WW'(signed'(cst)) + ysq);
      end
      OP_ADD_CONST: begin
        cst_next = sat64(WW'(signed'(cst)) + WW'(signed'(vin)));
      end
      OP_ADD_QUAD: begin
        sq_next  = sat64(WW'(signed'(sq)) + WW'(signed'(ca)));
        lin_next = sat64(WW'(signed'(lin)) + WW'(signed'(cb)));
        cst_next = sat64(WW'(signed'(cst)) + WW'(signed'(cc)));
      end
      OP_CLEAR: begin
        sq_next  = '0;
        lin_next = '0;
        cst_next = '0;
      end
      default: begin
        sq_next = sq;
      end
    endcase
  end

  // when the serial unit gets a new job
  always_comb begin
    start_next = 1'b0;
    unique case (state)
      ST_IDLE: start_next = !fin && in_valid &&
                            (operation == OP_LOAD_OBS || operation == OP_ADD_OBS);
      ST_CHK:  start_next = (sq != '0);
      ST_BSQ:  start_next = done;
      ST_DVT:  start_next = done;
      ST_DVP:  start_next = done && (opr == OP_QUERY);
      ST_QMS:  start_next = done && q_found;
      ST_SQS:  start_next = done;
      default: start_next = 1'b0;
    endcase
  end

  // argmin: sign follows -b/(2a)
  assign am = (an == bn) ? (~pq + WW'(1)) : pq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      req.start <= 1'b0;
      fin       <= 1'b0;
      out_valid <= 1'b0;
      sq        <= '0;
      lin       <= '0;
      cst       <= '0;
    end else begin
      req.start <= start_next;
      if (state == ST_IDLE && fin && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (fin && (!out_valid || !out_stall)) begin
            fin <= 1'b0;
          end else if (in_valid && !fin) begin
            if (operation == OP_LOAD_OBS || operation == OP_ADD_OBS) begin
              req.mode  <= MODE_MUL;
              req.num   <= WW'(mv_in);
              req.den   <= mv_in;
              state     <= ST_SQY;
            end else begin
              state <= ST_UPD;
            end
          end
        end
        ST_SQY: begin
          if (done) state <= ST_UPD;
        end
        ST_UPD: begin
          sq    <= sq_next;
          lin   <= lin_next;
          cst   <= cst_next;
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (sq == '0) begin
            fin   <= 1'b1;
            state <= ST_IDLE;
          end else begin
            req.mode  <= MODE_MUL;
            req.num   <= WW'(mb);
            req.den   <= mb;
            state     <= ST_BSQ;
          end
        end
        ST_BSQ: begin
          if (done) begin
            req.mode  <= MODE_DIV;
            req.num   <= res;
            req.den   <= ma;
            state     <= ST_DVT;
          end
        end
        ST_DVT: begin
          if (done) begin
            req.mode  <= MODE_DIV;
            req.num   <= WW'(mb) << FRAC_BITS;
            req.den   <= ma;
            state     <= ST_DVP;
          end
        end
        ST_DVP: begin
          if (done) begin
            if (opr == OP_QUERY) begin
              req.mode  <= MODE_MUL;
              req.num   <= WW'(ma);
              req.den   <= cm;
              state     <= ST_QMS;
            end else begin
              fin   <= 1'b1;
              state <= ST_IDLE;
            end
          end
        end
        ST_QMS: begin
          if (done) begin
            if (q_found) begin
              req.mode  <= MODE_SQRT;
              req.num   <= q_dq;
              req.den   <= ma;
              state     <= ST_SQS;
            end else begin
              fin   <= 1'b1;
              state <= ST_IDLE;
            end
          end
        end
        ST_SQS: begin
          if (done) begin
            req.mode  <= MODE_DIV;
            req.num   <= WW'(res[DW-1:0]) << FRAC_BITS;
            req.den   <= ma;
            state     <= ST_DVR;
          end
        end
        ST_DVR: begin
          if (done) begin
            fin   <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload side: latched word, intermediates and the output word
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid && !in_stall && !fin) begin
      opr   <= operation;
      vin   <= value;
      ca    <= coef_a;
      cb    <= coef_b;
      cc    <= coef_c;
      found <= 1'b0;
      degen <= 1'b0;
    end
    if (state == ST_CHK) degen <= (sq == '0);
    if (state == ST_BSQ && done) bsq <= res;
    if (state == ST_DVT && done) tq <= res >> 2;
    if (state == ST_DVP && done) pq <= res >> 1;
    if (state == ST_QMS && done) found <= q_found;
    if (state == ST_DVR && done) rq <= res;
    if (state == ST_IDLE && fin && (!out_valid || !out_stall)) begin
      degenerate     <= degen;
      interval_found <= found & ~degen;
      if (degen) begin
        min_value    <= '0;
        min_position <= '0;
      end else begin
        min_value    <= sat64(WW'(signed'(cst)) + (an ? tq : (~tq + WW'(1))));
        min_position <= sat64(am);
      end
      if (found && !degen) begin
        interval_low  <= sat64(am - rq);
        interval_high <= sat64(am + rq);
      end else begin
        interval_low  <= '0;
        interval_high <= '0;
      end
    end
  end

  `QCA_CHECK(a_done_in_wait, done |-> (state != ST_IDLE && state != ST_UPD && state != ST_CHK), "serial unit finished outside a wait state")
  `QCA_CHECK(a_obs_squares, (in_valid && !in_stall && !fin && operation == OP_LOAD_OBS) |=> (state == ST_SQY), "observation load skipped the square")
  `QCA_CHECK(a_degen_zero, (out_valid && degenerate) |-> (min_value == '0 && min_position == '0 && !interval_found), "degenerate result carries values")
  `QCA_CHECK(a_one_hot, $onehot(state), "sequencer state not one-hot")

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import qca_pkg::*;

  typedef logic [127:0] wide_t;

  typedef struct {
    logic [63:0] minv;
    logic [63:0] pos;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        found;
    logic        degen;
  } cost_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] operation = OP_CLEAR;
  logic signed [63:0] value = '0;
  logic signed [63:0] coef_a = '0;
  logic signed [63:0] coef_b = '0;
  logic signed [63:0] coef_c = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [63:0] min_value, min_position, interval_low, interval_high;
  logic interval_found, degenerate;

  quadratic_cost_accumulator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .value(value),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .min_value(min_value), .min_position(min_position),
    .interval_low(interval_low), .interval_high(interval_high),
    .interval_found(interval_found), .degenerate(degenerate)
  );

  // predictor state: the three coefficients of the cost
  logic [63:0] sq_coef = '0;
  logic [63:0] lin_coef = '0;
  logic [63:0] k_coef = '0;

  cost_result_t pending_results[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit stall_quiet = 1'b0;

  initial forever #5 clk = ~clk;

  // ---------------- fixed point helpers ----------------
  function automatic wide_t sx(logic [63:0] v);
    return {{64{v[63]}}, v};
  endfunction

  function automatic logic [63:0] clamp64(wide_t x);
    if (x[127:63] == '0 || x[127:63] == '1) return x[63:0];
    return x[127] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic logic [63:0] root128(wide_t n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (n >= wide_t'(t) * wide_t'(t)) r = t;
    end
    return r;
  endfunction

  // update the coefficients for one word and work out its result
  function automatic cost_result_t predict_cost(logic [2:0] op, logic [63:0] v,
                                                logic [63:0] qa, logic [63:0] qb,
                                                logic [63:0] qc);
    cost_result_t res;
    wide_t m2y, ysq, bsq, t, p, am, cl, qm, quarter, dq, rr;
    logic [63:0] one, ma, mb, cm, s;
    logic an, bn, cn, qpos, eq;
    one = 64'd1 << FRAC_BITS;
    m2y = -(sx(v) << 1);
    ysq = (wide_t'(abs64(v)) * wide_t'(abs64(v))) >> FRAC_BITS;
    res = '{default: '0};
    case (op)
      OP_LOAD_OBS: begin
        sq_coef = one; lin_coef = clamp64(m2y); k_coef = clamp64(ysq);
      end
      OP_ADD_OBS: begin
        sq_coef = clamp64(sx(sq_coef) + sx(one));
        lin_coef = clamp64(sx(lin_coef) + m2y);
        k_coef = clamp64(sx(k_coef) + ysq);
      end
      OP_ADD_CONST: k_coef = clamp64(sx(k_coef) + sx(v));
      OP_ADD_QUAD: begin
        sq_coef = clamp64(sx(sq_coef) + sx(qa));
        lin_coef = clamp64(sx(lin_coef) + sx(qb));
        k_coef = clamp64(sx(k_coef) + sx(qc));
      end
      OP_CLEAR: begin
        sq_coef = '0; lin_coef = '0; k_coef = '0;
      end
      default: ;
    endcase
    if (sq_coef == '0) begin
      res.degen = 1'b1;
      return res;
    end
    ma = abs64(sq_coef); mb = abs64(lin_coef);
    an = sq_coef[63]; bn = lin_coef[63];
    bsq = wide_t'(mb) * wide_t'(mb);
    t = (bsq / wide_t'(ma)) >> 2;
    p = ((wide_t'(mb) << FRAC_BITS) / wide_t'(ma)) >> 1;
    am = (an == bn) ? -p : p;
    res.minv = clamp64(sx(k_coef) + (an ? t : -t));
    res.pos = clamp64(am);
    if (op == OP_QUERY) begin
      cl = sx(k_coef) - sx(v);
      cn = cl[127];
      cm = cn ? 64'((-cl)) : cl[63:0];
      qm = wide_t'(ma) * wide_t'(cm);
      quarter = bsq >> 2;
      dq = '0;
      qpos = ((an ^ cn) == 1'b0) && (qm != '0);
      if (!qpos) begin
        res.found = (bsq != '0) || (qm != '0);
        dq = quarter + qm;
      end else if (quarter >= qm) begin
        eq = (quarter == qm);
        res.found = !eq || (bsq[1:0] != 2'b00);
        dq = quarter - qm;
      end
      if (res.found) begin
        s = root128(dq);
        rr = (wide_t'(s) << FRAC_BITS) / wide_t'(ma);
        res.lo = clamp64(am - rr);
        res.hi = clamp64(am + rr);
      end
    end
    return res;
  endfunction

  // ---------------- word driver ----------------
  int burst_left = 0;

  task automatic send_word(logic [2:0] op, logic [63:0] v, logic [63:0] qa = '0,
                           logic [63:0] qb = '0, logic [63:0] qc = '0);
    int gap;
    // sender works in bursts, with random gaps in between
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 400);
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    operation <= op; value <= v; coef_a <= qa; coef_b <= qb; coef_c <= qc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // word taken at this edge; expectation logged in order of acceptance
    pending_results.push_back(predict_cost(op, v, qa, qb, qc));
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  // drop valid when the caller pauses between tests
  task automatic idle_sender();
    if (burst_left != 0) in_valid <= 1'b0;
    burst_left = 0;
  endtask

  // ---------------- checker ----------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  always @(posedge clk) begin
    cost_result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", 64'd1, 64'd0);
      end else begin
        w = pending_results.pop_front();
        if (min_value !== w.minv) report_mismatch("min_value", min_value, w.minv);
        if (min_position !== w.pos) report_mismatch("min_position", min_position, w.pos);
        if (interval_low !== w.lo) report_mismatch("interval_low", interval_low, w.lo);
        if (interval_high !== w.hi) report_mismatch("interval_high", interval_high, w.hi);
        if (interval_found !== w.found)
          report_mismatch("interval_found", 64'(interval_found), 64'(w.found));
        if (degenerate !== w.degen)
          report_mismatch("degenerate", 64'(degenerate), 64'(w.degen));
      end
    end
  end

  // receiver stall pattern: runs of stall and no stall, quiet spells, long hold-offs
  initial begin
    int run;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end else if (stall_quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 40);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (run) @(posedge clk);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 10_000_000) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- random field values ----------------
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly modest Q32.32 numbers, sometimes extremes or full random
  function automatic logic [63:0] rand_fixed();
    case ($urandom_range(0, 9))
      0: return rand64();
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'(signed'($urandom_range(0, 8)) - 4);
      default: return 64'(signed'({$urandom_range(0, 1) ? 32'hffff_ffff : 32'h0,
                                   $urandom()})) <<< $urandom_range(0, 40);
    endcase
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    logic [63:0] one;
    one = 64'd1 << FRAC_BITS;
    send_word(OP_QUERY, '0);
    send_word(OP_LOAD_OBS, 3 * one);
    send_word(OP_QUERY, 5 * one);
    send_word(OP_QUERY, 3 * one);
    send_word(OP_QUERY, -one);
    send_word(OP_ADD_OBS, -one);
    send_word(OP_ADD_CONST, one);
    send_word(OP_QUERY, 10 * one);
    send_word(OP_LOAD_OBS, 64'h7fff_ffff_ffff_ffff);
    send_word(OP_ADD_OBS, 64'h8000_0000_0000_0000);
    send_word(OP_QUERY, 64'h8000_0000_0000_0000);
    send_word(OP_ADD_QUAD, '0, -4 * one, one, 64'h7fff_ffff_ffff_ffff);
    send_word(OP_QUERY, 64'h7fff_ffff_ffff_ffff);
    send_word(3'd6, rand64());
    send_word(3'd7, rand64());
    send_word(OP_CLEAR, rand64());
    send_word(OP_ADD_QUAD, -one, '0, '0);
    send_word(OP_QUERY, one);
    send_word(OP_QUERY, -one);
    send_word(OP_ADD_QUAD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
              64'h8000_0000_0000_0000);
    send_word(OP_QUERY, '0);
    send_word(OP_ADD_QUAD, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
              64'hffff_ffff_ffff_ffff);
    send_word(OP_QUERY, 64'hffff_ffff_ffff_ffff);
    send_word(OP_CLEAR, '0);
    idle_sender();
  endtask

  task automatic test_random(int n);
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      // observations and queries dominate the random mix of operations
      case ($urandom_range(0, 19))
        0, 1, 2: op = OP_LOAD_OBS;
        3, 4, 5, 6: op = OP_ADD_OBS;
        7, 8: op = OP_ADD_CONST;
        9, 10: op = OP_ADD_QUAD;
        11: op = OP_CLEAR;
        12: op = 3'($urandom_range(6, 7));
        default: op = OP_QUERY;
      endcase
      send_word(op, rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
    end
    idle_sender();
  endtask

  // receiver stops taking results while words keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) send_word(OP_QUERY, rand_fixed());
    idle_sender();
  endtask

  task automatic test_no_stall_stretch();
    stall_quiet = 1'b1;
    for (int i = 0; i < 40; i++) send_word(OP_ADD_OBS, rand_fixed());
    idle_sender();
    stall_quiet = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(800);
    test_backpressure();
    test_no_stall_stretch();
    test_random(780);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
